### hdl/fmols_pkg.sv
// types, constants and key-scale tables shared by the operator level scaler
`default_nettype none

package fmols_pkg;

    localparam int unsigned CH_W       = 3;
    localparam int unsigned SENS_W     = 32;
    localparam int unsigned BASE_W     = 28;
    localparam int unsigned LVL_W      = 7;
    localparam int unsigned NUM_OPS    = 4;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned KS_IDX_W   = 6;
    localparam int unsigned KS_W       = 8;
    localparam int unsigned EXTRA_W    = 8;
    localparam int unsigned MAG_W      = 4;
    localparam int unsigned PROD_W     = KS_W + MAG_W;
    localparam int unsigned TERM_W     = PROD_W - 7;
    localparam int unsigned SUM_W      = 9;
    localparam int unsigned ALG_W      = 3;

    localparam logic [LVL_W-1:0] LEVEL_MAX = 7'h7F;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_UPDATE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [SENS_W-1:0] sens;
    } t_patch_entry;

    typedef struct packed {
        logic [7:0]          sens;
        logic [KS_IDX_W-1:0] note_idx;
        logic [LVL_W-1:0]    base;
        logic [EXTRA_W-1:0]  extra;
        logic                add_extra;
    } t_op_req;

    localparam logic [ALG_W-1:0] OP_ALG_LIMIT [NUM_OPS] = '{3'd7, 3'd5, 3'd4, 3'd0};

    localparam logic [KS_W-1:0] KS_RISE [64] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05,
        8'h0A, 8'h0F, 8'h14, 8'h19, 8'h1E, 8'h22, 8'h27, 8'h2C,
        8'h31, 8'h36, 8'h3B, 8'h40, 8'h45, 8'h4A, 8'h4F, 8'h54,
        8'h59, 8'h5E, 8'h62, 8'h67, 8'h6C, 8'h71, 8'h76, 8'h7B,
        8'h80, 8'h85, 8'h8A, 8'h8F, 8'h94, 8'h99, 8'h9E, 8'hA2,
        8'hA7, 8'hAC, 8'hB1, 8'hB6, 8'hBB, 8'hC0, 8'hC5, 8'hCA,
        8'hCF, 8'hD4, 8'hD9, 8'hDE, 8'hE2, 8'hE7, 8'hEC, 8'hF1,
        8'hF6, 8'hFB, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };

    localparam logic [KS_W-1:0] KS_FALL [64] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFE, 8'hFD, 8'hFC, 8'hFA, 8'hF8, 8'hF6, 8'hF3, 8'hF0,
        8'hEC, 8'hE8, 8'hE4, 8'hDF, 8'hDA, 8'hD4, 8'hCF, 8'hC8,
        8'hC2, 8'hBB, 8'hB3, 8'hAB, 8'hA3, 8'h9B, 8'h92, 8'h89,
        8'h7F, 8'h75, 8'h6C, 8'h63, 8'h5B, 8'h53, 8'h4B, 8'h43,
        8'h3C, 8'h36, 8'h2F, 8'h2A, 8'h24, 8'h1F, 8'h1A, 8'h16,
        8'h12, 8'h0E, 8'h0B, 8'h08, 8'h06, 8'h04, 8'h02, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage

`default_nettype wire

### hdl/fmols_patch_table.sv
// per-channel patch table: valid flags with reset, sensitivity words without
`default_nettype none

module fmols_patch_table #(
    parameter int unsigned NUM_CHANNELS = 8,
    parameter int unsigned IDX_W        = 3
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [IDX_W-1:0]               i_wr_idx,
    input  wire fmols_pkg::t_patch_entry        i_wr_entry,
    input  wire logic [IDX_W-1:0]               i_rd_idx,
    output fmols_pkg::t_patch_entry             o_rd_entry
);

    logic                          r_valid [NUM_CHANNELS];
    logic [fmols_pkg::SENS_W-1:0]  r_sens  [NUM_CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= i_wr_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_sens[i_wr_idx] <= i_wr_entry.sens;
        end
    end

    always_comb begin
        o_rd_entry.valid = r_valid[i_rd_idx];
        o_rd_entry.sens  = r_sens[i_rd_idx];
    end

endmodule

`default_nettype wire

### hdl/fmols_op_unit.sv
// shared operator unit: key-scale lookup, multiply, add and saturate
`default_nettype none

module fmols_op_unit (
    input  wire fmols_pkg::t_op_req            i_req,
    output logic [fmols_pkg::LVL_W-1:0]        o_level
);

    logic [fmols_pkg::KS_W-1:0]   factor;
    logic [fmols_pkg::PROD_W-1:0] prod;
    logic [fmols_pkg::TERM_W-1:0] term;
    logic [fmols_pkg::SUM_W-1:0]  sum;

    always_comb begin
        factor = i_req.sens[7] ? fmols_pkg::KS_FALL[i_req.note_idx]
                               : fmols_pkg::KS_RISE[i_req.note_idx];
        prod   = fmols_pkg::PROD_W'(factor)
               * fmols_pkg::PROD_W'(i_req.sens[fmols_pkg::MAG_W-1:0]);
        term   = prod[fmols_pkg::PROD_W-1:7];
        sum    = fmols_pkg::SUM_W'(term) + fmols_pkg::SUM_W'(i_req.base)
               + (i_req.add_extra ? fmols_pkg::SUM_W'(i_req.extra) : '0);
        o_level = (sum > fmols_pkg::SUM_W'(fmols_pkg::LEVEL_MAX))
                ? fmols_pkg::LEVEL_MAX : sum[fmols_pkg::LVL_W-1:0];
    end

endmodule

`default_nettype wire

### hdl/fm_operator_level_scaler_unit.sv
// top level of the operator level scaler: sequencer, item registers and result register
//
// Input channel: i_in_valid / o_in_stall, one transfer per command. A load command
// writes the channel's patch entry at the transfer; an update command reads it.
// Output channel: o_out_valid / i_out_stall, exactly one result per input transfer.
// A load, or an update that computes nothing (invalid entry, no note, channel out
// of range), goes from idle straight to the finish state; an update that computes
// levels first steps the one shared operator unit over the four operators, one
// operator a cycle, in the calc state. The finish state loads the result register
// once it is free, and the sequencer takes the next item only back in idle.
// o_in_stall is high while an item is being worked on.
// When the receiver stalls, the result register holds its value; the next item is
// still taken and worked on, and waits to be moved across until the register frees.
// Reset clears every patch entry to invalid and empties the result register.
`default_nettype none

module fm_operator_level_scaler_unit #(
    parameter int unsigned NUM_CHANNELS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_in_cmd,
    input  wire logic [fmols_pkg::CH_W-1:0]          i_in_channel,
    input  wire logic                                i_in_patch_valid,
    input  wire logic [fmols_pkg::SENS_W-1:0]        i_in_patch_sens,
    input  wire logic                                i_in_note_active,
    input  wire logic [6:0]                          i_in_note_number,
    input  wire logic [6:0]                          i_in_note_velocity,
    input  wire logic [6:0]                          i_in_channel_volume,
    input  wire logic [fmols_pkg::ALG_W-1:0]         i_in_algorithm,
    input  wire logic [fmols_pkg::BASE_W-1:0]        i_in_base_levels,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [fmols_pkg::CH_W-1:0]               o_out_channel_out,
    output logic                                     o_out_updated,
    output logic [fmols_pkg::LVL_W-1:0]              o_out_level_op0,
    output logic [fmols_pkg::LVL_W-1:0]              o_out_level_op1,
    output logic [fmols_pkg::LVL_W-1:0]              o_out_level_op2,
    output logic [fmols_pkg::LVL_W-1:0]              o_out_level_op3
);

    localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    fmols_pkg::t_state r_state, n_state;

    logic                             in_xfer;
    logic                             in_range;
    logic                             is_update;
    logic [IDX_W-1:0]                 tbl_idx;
    logic                             tbl_wr_en;
    fmols_pkg::t_patch_entry          tbl_wr_entry;
    fmols_pkg::t_patch_entry          tbl_rd_entry;
    logic                             do_calc;
    logic                             calc_en;
    logic                             out_load;
    logic                             last_op;
    fmols_pkg::t_op_req               op_req;
    logic [fmols_pkg::LVL_W-1:0]      op_level;

    logic [fmols_pkg::CH_W-1:0]       r_channel;
    logic                             r_updated;
    logic [fmols_pkg::SENS_W-1:0]     r_sens;
    logic [fmols_pkg::KS_IDX_W-1:0]   r_note_idx;
    logic [fmols_pkg::EXTRA_W-1:0]    r_extra;
    logic [fmols_pkg::ALG_W-1:0]      r_alg;
    logic [fmols_pkg::BASE_W-1:0]     r_base;
    logic [fmols_pkg::OP_W-1:0]       r_op;
    logic [fmols_pkg::LVL_W-1:0]      r_level [fmols_pkg::NUM_OPS];

    logic                             r_out_valid;
    logic [fmols_pkg::CH_W-1:0]       r_out_channel;
    logic                             r_out_updated;
    logic [fmols_pkg::LVL_W-1:0]      r_out_level [fmols_pkg::NUM_OPS];

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign in_range  = (32'(i_in_channel) < NUM_CHANNELS);
    assign is_update = (i_in_cmd == fmols_pkg::CMD_UPDATE);
    assign tbl_idx   = IDX_W'(i_in_channel);
    assign tbl_wr_en = in_xfer && !is_update && in_range;
    assign tbl_wr_entry.valid = i_in_patch_valid;
    assign tbl_wr_entry.sens  = i_in_patch_sens;
    assign do_calc   = is_update && in_range && tbl_rd_entry.valid && i_in_note_active;
    assign last_op   = (r_op == fmols_pkg::OP_W'(fmols_pkg::NUM_OPS - 1));

    fmols_patch_table #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (tbl_wr_en),
        .i_wr_idx   (tbl_idx),
        .i_wr_entry (tbl_wr_entry),
        .i_rd_idx   (tbl_idx),
        .o_rd_entry (tbl_rd_entry)
    );

    always_comb begin
        op_req.sens      = r_sens[r_op*8 +: 8];
        op_req.note_idx  = r_note_idx;
        op_req.base      = r_base[r_op*fmols_pkg::LVL_W +: fmols_pkg::LVL_W];
        op_req.extra     = r_extra;
        op_req.add_extra = (r_alg >= fmols_pkg::OP_ALG_LIMIT[r_op]);
    end

    fmols_op_unit u_op (
        .i_req   (op_req),
        .o_level (op_level)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fmols_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = do_calc ? fmols_pkg::ST_CALC : fmols_pkg::ST_FIN;
                end
            end
            fmols_pkg::ST_CALC: begin
                if (last_op) begin
                    n_state = fmols_pkg::ST_FIN;
                end
            end
            fmols_pkg::ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = fmols_pkg::ST_IDLE;
                end
            end
            default: n_state = fmols_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        calc_en    = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            fmols_pkg::ST_IDLE: o_in_stall = 1'b0;
            fmols_pkg::ST_CALC: calc_en = 1'b1;
            fmols_pkg::ST_FIN:  out_load = !r_out_valid || !i_out_stall;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fmols_pkg::ST_IDLE;
            r_op        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_op <= '0;
            end else if (calc_en) begin
                r_op <= r_op + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_channel  <= i_in_channel;
            r_updated  <= do_calc;
            r_sens     <= tbl_rd_entry.sens;
            r_note_idx <= i_in_note_number[6:1];
            r_extra    <= fmols_pkg::EXTRA_W'(fmols_pkg::LEVEL_MAX - i_in_channel_volume)
                        + fmols_pkg::EXTRA_W'(fmols_pkg::LEVEL_MAX - i_in_note_velocity);
            r_alg      <= i_in_algorithm;
            r_base     <= i_in_base_levels;
            for (int i = 0; i < int'(fmols_pkg::NUM_OPS); i++) begin
                r_level[i] <= '0;
            end
        end else if (calc_en) begin
            r_level[r_op] <= op_level;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_channel <= r_channel;
            r_out_updated <= r_updated;
            r_out_level   <= r_level;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_channel_out = r_out_channel;
    assign o_out_updated     = r_out_updated;
    assign o_out_level_op0   = r_out_level[0];
    assign o_out_level_op1   = r_out_level[1];
    assign o_out_level_op2   = r_out_level[2];
    assign o_out_level_op3   = r_out_level[3];

endmodule

`default_nettype wire

### hdl/fmols_checker.sv
// port-level checker for the operator level scaler, bound to the top level
`default_nettype none

module fmols_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_stall,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [fmols_pkg::CH_W-1:0]    o_out_channel_out,
    input  wire logic                          o_out_updated,
    input  wire logic [fmols_pkg::LVL_W-1:0]   o_out_level_op0,
    input  wire logic [fmols_pkg::LVL_W-1:0]   o_out_level_op1,
    input  wire logic [fmols_pkg::LVL_W-1:0]   o_out_level_op2,
    input  wire logic [fmols_pkg::LVL_W-1:0]   o_out_level_op3
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_channel_out)
            && $stable(o_out_updated) && $stable(o_out_level_op0)
            && $stable(o_out_level_op1) && $stable(o_out_level_op2)
            && $stable(o_out_level_op3))
        else $error("stalled result changed");

    // a result without update carries zero levels
    a_zero_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_updated |-> o_out_level_op0 == '0
            && o_out_level_op1 == '0 && o_out_level_op2 == '0 && o_out_level_op3 == '0)
        else $error("levels not zero on a result without update");

    // one item at a time
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in work");

    // a new result only appears while an item was in work
    a_out_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item in work");

endmodule

bind fm_operator_level_scaler_unit fmols_checker u_fmols_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_out_channel_out (o_out_channel_out),
    .o_out_updated     (o_out_updated),
    .o_out_level_op0   (o_out_level_op0),
    .o_out_level_op1   (o_out_level_op1),
    .o_out_level_op2   (o_out_level_op2),
    .o_out_level_op3   (o_out_level_op3)
);

`default_nettype wire
